/* hw/rtl/dds_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dds_pkg;

  localparam int MAX_SVC   = 8;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = IDX_W + 1;
  localparam int FRESH_W   = 17;
  localparam int TAG_W     = 32;
  localparam int EDGE_W    = MAX_SVC * MAX_SVC;

  localparam logic [FRESH_W-1:0] FRESH_MAX = 17'd100000;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_RESULT = 1'b1;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  // Element [i][j] is set when service i feeds service j (bit i*8+j).
  typedef logic [MAX_SVC-1:0][MAX_SVC-1:0] matrix_t;
  typedef logic [MAX_SVC-1:0]              svc_mask_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } dds_cmd_t;

  typedef struct packed {
    logic pend_any;
    logic pend_last;
    logic slot_free;
  } dds_status_t;

  function automatic logic [IDX_W-1:0] lowest_index(input svc_mask_t m);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int k = MAX_SVC - 1; k >= 0; k--) begin
      if (m[k]) begin
        idx = IDX_W'(k);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dag_dependency_scoreboard_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Dataflow dependency scoreboard for up to SERVICES services. A start item
// loads the edge matrix and requests every root; a result item for a service
// index below SERVICES marks that service's output as received, requests
// every service whose inputs are now complete, and yields one final result
// for each sink it feeds. An item is taken, then its results leave one per
// cycle through the output register while it is not stalled, requests before
// final results, each in index order. The input side is stalled until the
// last result has entered the output register; the next item is taken as
// soon as it has.

module dag_dependency_scoreboard_unit #(
  parameter int SERVICES = 8
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         opcode,
  input  wire  [dds_pkg::EDGE_W-1:0]  dag_edges,
  input  wire  [dds_pkg::IDX_W-1:0]   service_index,
  input  wire  [dds_pkg::FRESH_W-1:0] freshness_ms,
  input  wire  [dds_pkg::TAG_W-1:0]   content_tag,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        kind,
  output logic [dds_pkg::IDX_W-1:0]   target_service,
  output logic [dds_pkg::FRESH_W-1:0] final_freshness_ms,
  output logic [dds_pkg::TAG_W-1:0]   final_content,
  output logic                        last
);
  import dds_pkg::*;

  dds_cmd_t    cmd;
  dds_status_t status;

  dds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dds_datapath #(
    .SERVICES (SERVICES)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .opcode             (opcode),
    .dag_edges          (dag_edges),
    .service_index      (service_index),
    .freshness_ms       (freshness_ms),
    .content_tag        (content_tag),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .kind               (kind),
    .target_service     (target_service),
    .final_freshness_ms (final_freshness_ms),
    .final_content      (final_content),
    .last               (last)
  );

endmodule

`default_nettype wire

/* hw/rtl/dds_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dds_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  dds_pkg::dds_status_t status,
  output dds_pkg::dds_cmd_t    cmd
);
  import dds_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.pend_any) begin
          state_next = ST_IDLE;
        end else if (status.slot_free && status.pend_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // No item is taken while reset is held.
  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      ST_EMIT: begin
        cmd.emit = status.pend_any && status.slot_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/dds_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module dds_datapath #(
  parameter int SERVICES = 8
) (
  input  wire                                clk,
  input  wire                                rst,
  input  dds_pkg::dds_cmd_t                  cmd,
  output dds_pkg::dds_status_t               status,
  input  wire                                opcode,
  input  wire  [dds_pkg::EDGE_W-1:0]         dag_edges,
  input  wire  [dds_pkg::IDX_W-1:0]          service_index,
  input  wire  [dds_pkg::FRESH_W-1:0]        freshness_ms,
  input  wire  [dds_pkg::TAG_W-1:0]          content_tag,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               kind,
  output logic [dds_pkg::IDX_W-1:0]          target_service,
  output logic [dds_pkg::FRESH_W-1:0]        final_freshness_ms,
  output logic [dds_pkg::TAG_W-1:0]          final_content,
  output logic                               last
);
  import dds_pkg::*;

  matrix_t             edge_matrix;
  matrix_t             received_matrix;
  svc_mask_t           tracked_mask;
  svc_mask_t           issued_mask;
  svc_mask_t           sink_mask;
  logic [FRESH_W-1:0]  lowest_freshness;
  svc_mask_t           pend_req;
  svc_mask_t           pend_fin;
  logic [TAG_W-1:0]    tag;

  matrix_t             valid_mask;
  matrix_t             new_edges;
  svc_mask_t           has_in;
  svc_mask_t           has_out;
  matrix_t             recv_marked;
  svc_mask_t           ready;
  svc_mask_t           feeds;
  logic                svc_ok;
  logic [FRESH_W-1:0]  fresh_sat;
  logic [FRESH_W-1:0]  fresh_low;

  logic                pick_final;
  svc_mask_t           pick_src;
  logic [IDX_W-1:0]    pick_idx;
  svc_mask_t           pend_req_after;
  svc_mask_t           pend_fin_after;

  // Only edges between services that exist are kept.
  always_comb begin
    for (int i = 0; i < MAX_SVC; i++) begin
      for (int j = 0; j < MAX_SVC; j++) begin
        valid_mask[i][j] = (i < SERVICES) && (j < SERVICES);
      end
    end
  end

  assign new_edges = matrix_t'(dag_edges) & valid_mask;

  always_comb begin
    has_in  = '0;
    has_out = '0;
    for (int i = 0; i < MAX_SVC; i++) begin
      has_out[i] = |new_edges[i];
      for (int j = 0; j < MAX_SVC; j++) begin
        has_in[j] = has_in[j] | new_edges[i][j];
      end
    end
  end

  assign svc_ok    = {1'b0, service_index} < CNT_W'(SERVICES);
  assign fresh_sat = (freshness_ms > FRESH_MAX) ? FRESH_MAX : freshness_ms;
  assign fresh_low = (fresh_sat < lowest_freshness) ? fresh_sat : lowest_freshness;
  assign feeds     = edge_matrix[service_index];

  // Readiness is judged on the received state after this result is marked.
  always_comb begin
    recv_marked = received_matrix;
    recv_marked[service_index] = received_matrix[service_index] | (feeds & tracked_mask);
    for (int j = 0; j < MAX_SVC; j++) begin
      ready[j] = tracked_mask[j] & ~issued_mask[j];
      for (int i = 0; i < MAX_SVC; i++) begin
        ready[j] = ready[j] & (~edge_matrix[i][j] | recv_marked[i][j]);
      end
    end
  end

  // Requests drain before final results; each drains lowest index first.
  assign pick_final     = (pend_req == '0);
  assign pick_src       = pick_final ? pend_fin : pend_req;
  assign pick_idx       = lowest_index(pick_src);
  assign pend_req_after = pend_req & (pend_req - svc_mask_t'(1));
  assign pend_fin_after = pick_final ? (pend_fin & (pend_fin - svc_mask_t'(1))) : pend_fin;

  assign status.pend_any  = (pend_req != '0) || (pend_fin != '0);
  assign status.pend_last = (pend_req_after == '0) && (pend_fin_after == '0);
  assign status.slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_matrix      <= '0;
      received_matrix  <= '0;
      tracked_mask     <= '0;
      issued_mask      <= '0;
      sink_mask        <= '0;
      lowest_freshness <= FRESH_MAX;
      pend_req         <= '0;
      pend_fin         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (opcode == OP_START) begin
          edge_matrix     <= new_edges;
          received_matrix <= '0;
          tracked_mask    <= has_out;
          sink_mask       <= has_in & ~has_out;
          issued_mask     <= has_out & ~has_in;
          pend_req        <= has_out & ~has_in;
          pend_fin        <= '0;
        end else if (svc_ok) begin
          lowest_freshness <= fresh_low;
          received_matrix  <= recv_marked;
          issued_mask      <= issued_mask | ready;
          pend_req         <= ready;
          pend_fin         <= sink_mask & feeds;
        end else begin
          pend_req <= '0;
          pend_fin <= '0;
        end
      end else if (cmd.emit) begin
        pend_req <= pend_req_after;
        pend_fin <= pend_fin_after;
        if (pick_final) begin
          received_matrix  <= '0;
          tracked_mask     <= '0;
          issued_mask      <= '0;
          lowest_freshness <= FRESH_MAX;
        end
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag <= content_tag;
    end
    if (cmd.emit) begin
      kind           <= pick_final ? KIND_FINAL : KIND_REQUEST;
      target_service <= pick_idx;
      if (pick_final) begin
        final_freshness_ms <= lowest_freshness;
        final_content      <= tag;
      end else begin
        final_freshness_ms <= '0;
        final_content      <= '0;
      end
      last <= status.pend_last;
    end
  end

  a_issued_tracked: assert property (@(posedge clk) disable iff (rst)
    (issued_mask & ~tracked_mask) == '0)
    else $error("issued service is not tracked");

  a_received_edges: assert property (@(posedge clk) disable iff (rst)
    (received_matrix & ~edge_matrix) == '0)
    else $error("received mark without an edge");

  a_emit_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> ((pend_req != '0) || (pend_fin != '0)))
    else $error("emit with nothing pending");

  a_fresh_range: assert property (@(posedge clk) disable iff (rst)
    lowest_freshness <= FRESH_MAX)
    else $error("lowest freshness out of range");

  a_no_load_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.emit))
    else $error("load and emit in the same cycle");

endmodule

`default_nettype wire

/* tb/sv/tb_dag_dependency_scoreboard_unit.sv */
`timescale 1ns / 1ps

module tb_dag_dependency_scoreboard_unit;
  import dds_pkg::*;

  localparam int NSVC         = MAX_SVC;
  localparam int RANDOM_ITEMS = 96;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE       = 16;

  typedef struct {
    logic               opcode;
    logic [EDGE_W-1:0]  edges;
    logic [IDX_W-1:0]   svc;
    logic [FRESH_W-1:0] fresh;
    logic [TAG_W-1:0]   tag;
    bit                 drain_first;
  } job_t;

  typedef struct {
    logic               kind;
    logic [IDX_W-1:0]   target;
    logic [FRESH_W-1:0] fresh;
    logic [TAG_W-1:0]   content;
    logic               last;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = OP_START;
  logic [EDGE_W-1:0]  dag_edges = '0;
  logic [IDX_W-1:0]   service_index = '0;
  logic [FRESH_W-1:0] freshness_ms = '0;
  logic [TAG_W-1:0]   content_tag = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic [IDX_W-1:0]   target_service;
  logic [FRESH_W-1:0] final_freshness_ms;
  logic [TAG_W-1:0]   final_content;
  logic               last;

  // Scoreboard copy kept by the checker.
  matrix_t            edge_m;
  matrix_t            recv_m;
  svc_mask_t          tracked;
  svc_mask_t          issued;
  svc_mask_t          sinks;
  logic [FRESH_W-1:0] low_fresh;

  job_t     pending_jobs[$];
  outcome_t due_outcomes[$];

  int items_in = 0;
  int n_sent = 0;
  int n_total = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_finals = 0;
  int n_starts = 0;
  int n_reports = 0;
  int quiet = 0;
  int gap_left = 0;
  int burst_left = 1;
  int cyc = 0;
  int stall_mode = 0;

  dag_dependency_scoreboard_unit #(
    .SERVICES(NSVC)
  ) u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .opcode             (opcode),
    .dag_edges          (dag_edges),
    .service_index      (service_index),
    .freshness_ms       (freshness_ms),
    .content_tag        (content_tag),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .kind               (kind),
    .target_service     (target_service),
    .final_freshness_ms (final_freshness_ms),
    .final_content      (final_content),
    .last               (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic outcome_t make_outcome(input logic k, input int target,
                                            input logic [FRESH_W-1:0] f,
                                            input logic [TAG_W-1:0] c);
    outcome_t o;
    o.kind    = k;
    o.target  = IDX_W'(target);
    o.fresh   = f;
    o.content = c;
    o.last    = 1'b0;
    return o;
  endfunction

  // Appends one item to the end of the pending queue.
  task automatic queue_job(input job_t jb);
    pending_jobs.insert(pending_jobs.size(), jb);
  endtask

  // Applies one accepted item to the scoreboard copy and queues the
  // requests and final results it should produce.
  task automatic advance_scoreboard(input job_t it);
    svc_mask_t          has_in;
    svc_mask_t          has_out;
    svc_mask_t          roots;
    outcome_t           outs[$];
    logic [FRESH_W-1:0] f;
    int                 s;
    bit                 ready;
    if (it.opcode == OP_START) begin
      has_in  = '0;
      has_out = '0;
      for (int i = 0; i < MAX_SVC; i++) begin
        for (int j = 0; j < MAX_SVC; j++) begin
          edge_m[i][j] = it.edges[i*MAX_SVC + j] && (i < NSVC) && (j < NSVC);
          if (edge_m[i][j]) begin
            has_out[i] = 1'b1;
            has_in[j]  = 1'b1;
          end
        end
      end
      roots   = has_out & ~has_in;
      tracked = has_out;
      sinks   = has_in & ~has_out;
      recv_m  = '0;
      issued  = roots;
      for (int i = 0; i < NSVC; i++) begin
        if (roots[i]) begin
          outs.insert(outs.size(), make_outcome(KIND_REQUEST, i, '0, '0));
        end
      end
    end else if (int'(it.svc) < NSVC) begin
      s = int'(it.svc);
      f = (it.fresh > FRESH_MAX) ? FRESH_MAX : it.fresh;
      if (f < low_fresh) begin
        low_fresh = f;
      end
      for (int j = 0; j < NSVC; j++) begin
        if (tracked[j] && edge_m[s][j]) begin
          recv_m[s][j] = 1'b1;
        end
      end
      for (int j = 0; j < NSVC; j++) begin
        if (tracked[j] && !issued[j]) begin
          ready = 1'b1;
          for (int i = 0; i < NSVC; i++) begin
            if (edge_m[i][j] && !recv_m[i][j]) begin
              ready = 1'b0;
            end
          end
          if (ready) begin
            issued[j] = 1'b1;
            outs.insert(outs.size(), make_outcome(KIND_REQUEST, j, '0, '0));
          end
        end
      end
      // Each sink reached clears the tracker, so later sinks see it empty.
      for (int j = 0; j < NSVC; j++) begin
        if (sinks[j] && edge_m[s][j]) begin
          outs.insert(outs.size(), make_outcome(KIND_FINAL, j, low_fresh, it.tag));
          recv_m    = '0;
          tracked   = '0;
          issued    = '0;
          low_fresh = FRESH_MAX;
        end
      end
    end
    if (outs.size() > 0) begin
      outs[outs.size()-1].last = 1'b1;
    end
    foreach (outs[k]) begin
      due_outcomes.insert(due_outcomes.size(), outs[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [TAG_W-1:0] exp_v,
                             input logic [TAG_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("Field %s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  function automatic logic [FRESH_W-1:0] random_fresh();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return FRESH_W'($urandom_range(100001, 131071));
    end else if (pick == 1) begin
      return '0;
    end
    return FRESH_W'($urandom_range(0, 100000));
  endfunction

  // Fields that the opcode does not use carry random values.
  function automatic job_t start_job(input logic [EDGE_W-1:0] e);
    job_t jb;
    jb.opcode      = OP_START;
    jb.edges       = e;
    jb.svc         = IDX_W'($urandom);
    jb.fresh       = FRESH_W'($urandom);
    jb.tag         = $urandom;
    jb.drain_first = 1'b0;
    return jb;
  endfunction

  function automatic job_t result_job(input int s, input logic [FRESH_W-1:0] f,
                                      input logic [TAG_W-1:0] t);
    job_t jb;
    jb.opcode      = OP_RESULT;
    jb.edges       = {$urandom, $urandom};
    jb.svc         = IDX_W'(s);
    jb.fresh       = f;
    jb.tag         = t;
    jb.drain_first = 1'b0;
    return jb;
  endfunction

  // A random graph, acyclic but for the odd self loop, then results from its
  // tracked services in dependency order, with stray results and early cut-off.
  task automatic queue_workflow();
    int                order[MAX_SVC];
    int                t;
    int                k;
    int                s;
    int                dens;
    logic [EDGE_W-1:0] e;
    job_t              jb;
    for (k = 0; k < MAX_SVC; k++) begin
      order[k] = k;
    end
    for (k = MAX_SVC - 1; k > 0; k--) begin
      t        = $urandom_range(0, k);
      s        = order[k];
      order[k] = order[t];
      order[t] = s;
    end
    dens = $urandom_range(1, 6);
    e    = '0;
    for (int a = 0; a < MAX_SVC; a++) begin
      for (int b = a + 1; b < MAX_SVC; b++) begin
        if ($urandom_range(0, 7) < dens) begin
          e[order[a]*MAX_SVC + order[b]] = 1'b1;
        end
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      s = $urandom_range(0, MAX_SVC - 1);
      e[s*MAX_SVC + s] = 1'b1;
    end
    jb             = start_job(e);
    jb.drain_first = ($urandom_range(0, 4) == 0);
    queue_job(jb);
    for (k = 0; k < MAX_SVC; k++) begin
      s = order[k];
      if ($urandom_range(0, 11) == 0) begin
        break;
      end
      if ($urandom_range(0, 9) == 0) begin
        queue_job(result_job($urandom_range(0, MAX_SVC - 1), random_fresh(), $urandom));
      end
      if (e[s*MAX_SVC +: MAX_SVC] != '0) begin
        queue_job(result_job(s, random_fresh(), $urandom));
      end
    end
  endtask

  // Driver: one item at a time from the pending queue, in bursts.
  always @(negedge clk) begin
    job_t nxt;
    logic v;
    v = in_valid;
    if (!rst && !(in_valid && items_in != n_sent)) begin
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_jobs.size() != 0 &&
                   !(pending_jobs[0].drain_first && due_outcomes.size() != 0)) begin
        nxt = pending_jobs.pop_front();
        opcode        <= nxt.opcode;
        dag_edges     <= nxt.edges;
        service_index <= nxt.svc;
        freshness_ms  <= nxt.fresh;
        content_tag   <= nxt.tag;
        v = 1'b1;
        n_sent++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid <= v;
  end

  // Receiver back-pressure switches at random among four modes.
  always @(negedge clk) begin
    cyc++;
    if (cyc % 50 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= (cyc % 4 != 0);
      default: out_stall <= ($urandom_range(0, 7) < 6);
    endcase
  end

  // Monitor: results are checked before the item taken at the same edge is
  // applied, since that item cannot have produced anything yet.
  always @(posedge clk) begin
    outcome_t want;
    job_t     got;
    if (rst) begin
      edge_m    = '0;
      recv_m    = '0;
      tracked   = '0;
      issued    = '0;
      sinks     = '0;
      low_fresh = FRESH_MAX;
      quiet     = 0;
    end else begin
      quiet++;
      if (out_valid && !out_stall) begin
        quiet = 0;
        n_checked++;
        if (kind == KIND_FINAL) begin
          n_finals++;
        end
        if (due_outcomes.size() == 0) begin
          $error("Unexpected result: kind %0d target %0d", kind, target_service);
          n_errors++;
        end else begin
          want = due_outcomes.pop_front();
          check_field("kind", TAG_W'(want.kind), TAG_W'(kind));
          check_field("target_service", TAG_W'(want.target), TAG_W'(target_service));
          check_field("final_freshness_ms", TAG_W'(want.fresh),
                      TAG_W'(final_freshness_ms));
          check_field("final_content", want.content, final_content);
          check_field("last", TAG_W'(want.last), TAG_W'(last));
        end
      end
      if (in_valid && !in_stall) begin
        quiet = 0;
        items_in++;
        got.opcode      = opcode;
        got.edges       = dag_edges;
        got.svc         = service_index;
        got.fresh       = freshness_ms;
        got.tag         = content_tag;
        got.drain_first = 1'b0;
        if (opcode == OP_START) begin
          n_starts++;
        end else begin
          n_reports++;
        end
        advance_scoreboard(got);
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int n_directed;
    int pick;
    // Result into an empty scoreboard, empty graph, then a full graph where
    // every service waits on all eight, so the last result issues eight.
    queue_job(result_job(3, 17'd5, 32'h0));
    queue_job(start_job('0));
    queue_job(start_job('1));
    queue_job(result_job(0, 17'h1FFFF, 32'hFFFF_FFFF));
    queue_job(result_job(1, 17'd100000, 32'h0));
    queue_job(result_job(2, 17'd100001, 32'h8000_0001));
    queue_job(result_job(3, 17'd0, 32'h5555_5555));
    queue_job(result_job(4, 17'd1, 32'hAAAA_AAAA));
    queue_job(result_job(5, 17'h0AAAA, 32'h1234_5678));
    queue_job(result_job(6, 17'h15555, 32'h7FFF_FFFF));
    queue_job(result_job(7, 17'd99999, 32'hFFFF_FFFE));
    // Chain 0 to 1 to 2 to 3, then the sink fed again with an empty tracker.
    queue_job(start_job(64'h0000_0000_0008_0402));
    queue_job(result_job(0, 17'd90000, 32'h0000_0001));
    queue_job(result_job(1, 17'd100000, 32'h0000_0002));
    queue_job(result_job(2, 17'd0, 32'hDEAD_0003));
    queue_job(result_job(3, 17'd10, 32'h0000_0004));
    queue_job(result_job(2, 17'd500, 32'h0000_0005));
    // One service feeding three sinks.
    queue_job(start_job(64'h0000_0000_0000_000E));
    queue_job(result_job(0, 17'd7, 32'hFFFF_FFFF));
    // Self loops.
    queue_job(start_job(64'h0000_0000_0000_0003));
    queue_job(result_job(0, 17'd12345, 32'h0BAD_CAFE));
    queue_job(start_job(64'h8000_0000_0000_0001));
    queue_job(result_job(7, 17'h1FFFF, 32'h0000_0007));
    queue_job(result_job(0, 17'd1, 32'h0000_0008));
    n_directed = pending_jobs.size();

    while (pending_jobs.size() < n_directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        queue_workflow();
      end else if (pick == 8) begin
        queue_job(start_job({$urandom, $urandom}));
      end else begin
        queue_job(result_job($urandom_range(0, MAX_SVC - 1), random_fresh(), $urandom));
      end
    end
    pending_jobs[n_directed].drain_first = 1'b1;
    n_total = pending_jobs.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_in != n_total) @(negedge clk);
    while (due_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Sent %0d items (%0d graph starts, %0d service results).",
             items_in, n_starts, n_reports);
    $display("Checked %0d outputs, %0d of them final results.", n_checked, n_finals);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
